@@ sv/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// shared types, constants and row codes of the look-at view matrix block
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // matrix row codes
   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_BACK  = 2'd2;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_type;

   typedef struct packed {
      logic        [1:0]  row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] shift;
      logic               degenerate;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] shift;
   } row_data_type;

   typedef struct packed {
      row_data_type [2:0] rows;
      logic               degenerate;
   } row_set_type;

endpackage

@@ sv/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// right-handed look-at view matrix in signed fixed point, three rows per item
// ----------------------------------------------------------------------------
//  channel  | ports               | moves
//  ---------+---------------------+----------------------------------------
//  request  | req_valid/req_stall | eye, target, up (req_type)
//  response | rsp_valid/rsp_stall | one matrix row per item (rsp_type)
//
//  each normalizer has a 31-stage square root and a FRAC_BITS+2 stage
//  divider. sustained rate is set by the row serializer, which sends three
//  rows per matrix and takes the next matrix only as the last row leaves.
//  synchronous reset clears the valid bits and the row counter only;
//  no clearing pass. a response stall freezes the whole pipeline once
//  its last stage holds an item the serializer cannot take; every stage
//  holds its item, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = FRAC_BITS + 3;       // unit axis component
   localparam int PW = 2 * AW;              // axis product
   localparam int CW = 2 * AW + 1;          // cross product component
   localparam int EW = AW + 32;             // axis times eye
   localparam int DW = AW + 34;             // dot product
   localparam int SB = 96 + 3 * AW + 1;     // sideband through second normalizer

   logic en;
   logic ser_ready;

   // ------------------------------------------------------------------
   // stage 0: register the item, form eye - target exactly
   // ------------------------------------------------------------------
   logic               v0_ff;
   logic signed [31:0] eye0_ff [3];
   logic signed [32:0] d0_ff   [3];
   logic signed [31:0] up0_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
      if (en) begin
         eye0_ff[0] <= req_data.eye_x;
         eye0_ff[1] <= req_data.eye_y;
         eye0_ff[2] <= req_data.eye_z;
         d0_ff[0]   <= 33'(req_data.eye_x) - 33'(req_data.target_x);
         d0_ff[1]   <= 33'(req_data.eye_y) - 33'(req_data.target_y);
         d0_ff[2]   <= 33'(req_data.eye_z) - 33'(req_data.target_z);
         up0_ff[0]  <= req_data.up_x;
         up0_ff[1]  <= req_data.up_y;
         up0_ff[2]  <= req_data.up_z;
      end
   end

   // ------------------------------------------------------------------
   // z = normalize(eye - target) and nu = normalize(up), side by side;
   // the eye rides along split over the two units
   // ------------------------------------------------------------------
   logic signed [AW-1:0] z_n  [3];
   logic signed [AW-1:0] nu_n [3];
   logic                 vz_n, vu_n, okz_n, oku_n;
   logic        [63:0]   eye_xy_n;
   logic        [31:0]   eye_z_n;
   logic signed [32:0]   up_ext [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up_ext[i] = 33'(up0_ff[i]);
      end
   end

   lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(33), .SIDE_W(64)) u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (d0_ff),
      .side_in   ({eye0_ff[0], eye0_ff[1]}),
      .out_valid (vz_n),
      .out_vec   (z_n),
      .out_ok    (okz_n),
      .side_out  (eye_xy_n)
   );

   lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(33), .SIDE_W(32)) u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (up_ext),
      .side_in   (eye0_ff[2]),
      .out_valid (vu_n),
      .out_vec   (nu_n),
      .out_ok    (oku_n),
      .side_out  (eye_z_n)
   );

   // ------------------------------------------------------------------
   // cross(nu, z): products, then differences
   // ------------------------------------------------------------------
   logic                 vc1_ff, okc1_ff;
   logic signed [PW-1:0] pc1_ff [6];
   logic signed [AW-1:0] zc1_ff [3];
   logic signed [31:0]   ec1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
      end else if (en) begin
         vc1_ff <= vz_n && vu_n;
      end
      if (en) begin
         pc1_ff[0] <= PW'(nu_n[1]) * PW'(z_n[2]);
         pc1_ff[1] <= PW'(nu_n[2]) * PW'(z_n[1]);
         pc1_ff[2] <= PW'(nu_n[2]) * PW'(z_n[0]);
         pc1_ff[3] <= PW'(nu_n[0]) * PW'(z_n[2]);
         pc1_ff[4] <= PW'(nu_n[0]) * PW'(z_n[1]);
         pc1_ff[5] <= PW'(nu_n[1]) * PW'(z_n[0]);
         zc1_ff    <= z_n;
         ec1_ff[0] <= $signed(eye_xy_n[63:32]);
         ec1_ff[1] <= $signed(eye_xy_n[31:0]);
         ec1_ff[2] <= $signed(eye_z_n);
         okc1_ff   <= okz_n && oku_n;
      end
   end

   logic                 vc2_ff, okc2_ff;
   logic signed [CW-1:0] cc2_ff [3];
   logic signed [AW-1:0] zc2_ff [3];
   logic signed [31:0]   ec2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc2_ff <= 1'b0;
      end else if (en) begin
         vc2_ff <= vc1_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cc2_ff[i] <= CW'(pc1_ff[2*i]) - CW'(pc1_ff[2*i+1]);
         end
         zc2_ff  <= zc1_ff;
         ec2_ff  <= ec1_ff;
         okc2_ff <= okc1_ff;
      end
   end

   // ------------------------------------------------------------------
   // x = normalize(cross(nu, z)); ok, eye and z ride along
   // ------------------------------------------------------------------
   logic signed [AW-1:0] x_n [3];
   logic                 vx_n, okx_n;
   logic        [SB-1:0] sb_in, sb_out;

   assign sb_in = {okc2_ff, ec2_ff[0], ec2_ff[1], ec2_ff[2],
                   zc2_ff[0], zc2_ff[1], zc2_ff[2]};

   lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(CW), .SIDE_W(SB)) u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc2_ff),
      .in_vec    (cc2_ff),
      .side_in   (sb_in),
      .out_valid (vx_n),
      .out_vec   (x_n),
      .out_ok    (okx_n),
      .side_out  (sb_out)
   );

   // ------------------------------------------------------------------
   // y = cross(z, x) rounded to FRAC_BITS: products, differences, round
   // ------------------------------------------------------------------
   logic                 vy1_ff, oky1_ff;
   logic signed [PW-1:0] py1_ff [6];
   logic signed [AW-1:0] xy1_ff [3];
   logic signed [AW-1:0] zy1_ff [3];
   logic signed [31:0]   ey1_ff [3];
   logic signed [AW-1:0] zs [3];
   logic signed [31:0]   es [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         zs[i] = $signed(sb_out[(2-i)*AW +: AW]);
         es[i] = $signed(sb_out[3*AW + (2-i)*32 +: 32]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vy1_ff <= 1'b0;
      end else if (en) begin
         vy1_ff <= vx_n;
      end
      if (en) begin
         py1_ff[0] <= PW'(zs[1]) * PW'(x_n[2]);
         py1_ff[1] <= PW'(zs[2]) * PW'(x_n[1]);
         py1_ff[2] <= PW'(zs[2]) * PW'(x_n[0]);
         py1_ff[3] <= PW'(zs[0]) * PW'(x_n[2]);
         py1_ff[4] <= PW'(zs[0]) * PW'(x_n[1]);
         py1_ff[5] <= PW'(zs[1]) * PW'(x_n[0]);
         xy1_ff    <= x_n;
         zy1_ff    <= zs;
         ey1_ff    <= es;
         oky1_ff   <= sb_out[SB-1] && okx_n;
      end
   end

   logic                 vy2_ff, oky2_ff;
   logic signed [CW-1:0] cy2_ff [3];
   logic signed [AW-1:0] xy2_ff [3];
   logic signed [AW-1:0] zy2_ff [3];
   logic signed [31:0]   ey2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vy2_ff <= 1'b0;
      end else if (en) begin
         vy2_ff <= vy1_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cy2_ff[i] <= CW'(py1_ff[2*i]) - CW'(py1_ff[2*i+1]);
         end
         xy2_ff  <= xy1_ff;
         zy2_ff  <= zy1_ff;
         ey2_ff  <= ey1_ff;
         oky2_ff <= oky1_ff;
      end
   end

   // half rounds toward plus infinity: add half, arithmetic shift
   logic                 vy3_ff, oky3_ff;
   logic signed [AW-1:0] ax3_ff [3][3];
   logic signed [31:0]   ey3_ff [3];
   logic signed [CW:0]   yr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         yr[i] = (($signed((CW+1)'(cy2_ff[i])) + $signed((CW+1)'(1) << (FRAC_BITS - 1)))
                  >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vy3_ff <= 1'b0;
      end else if (en) begin
         vy3_ff <= vy2_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ax3_ff[0][i] <= xy2_ff[i];
            ax3_ff[1][i] <= AW'(yr[i]);
            ax3_ff[2][i] <= zy2_ff[i];
         end
         ey3_ff  <= ey2_ff;
         oky3_ff <= oky2_ff;
      end
   end

   // ------------------------------------------------------------------
   // translation: nine products, three sums, then round and saturate
   // ------------------------------------------------------------------
   logic                 vd1_ff, okd1_ff;
   logic signed [EW-1:0] pd1_ff [3][3];
   logic signed [AW-1:0] ad1_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd1_ff <= 1'b0;
      end else if (en) begin
         vd1_ff <= vy3_ff;
      end
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               pd1_ff[r][k] <= EW'(ax3_ff[r][k]) * EW'(ey3_ff[k]);
            end
         end
         ad1_ff  <= ax3_ff;
         okd1_ff <= oky3_ff;
      end
   end

   logic                 vd2_ff, okd2_ff;
   logic signed [DW-1:0] dot2_ff [3];
   logic signed [AW-1:0] ad2_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd2_ff <= 1'b0;
      end else if (en) begin
         vd2_ff <= vd1_ff;
      end
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            dot2_ff[r] <= DW'(pd1_ff[r][0]) + DW'(pd1_ff[r][1]) + DW'(pd1_ff[r][2]);
         end
         ad2_ff  <= ad1_ff;
         okd2_ff <= okd1_ff;
      end
   end

   // negate, round, clamp to 32 bits; degenerate matrices read as zero
   row_set_type          set_n;
   logic signed [DW:0]   sr [3];
   logic signed [31:0]   sat [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sr[r] = ((-$signed((DW+1)'(dot2_ff[r]))) + $signed((DW+1)'(1) << (FRAC_BITS - 1)))
                 >>> FRAC_BITS;
         if (sr[r] > $signed((DW+1)'(32'sh7fffffff))) begin
            sat[r] = 32'sh7fffffff;
         end else if (sr[r] < $signed((DW+1)'(-33'sh080000000))) begin
            sat[r] = 32'sh80000000;
         end else begin
            sat[r] = 32'(sr[r]);
         end
         if (okd2_ff) begin
            set_n.rows[r].col0  = 32'(ad2_ff[r][0]);
            set_n.rows[r].col1  = 32'(ad2_ff[r][1]);
            set_n.rows[r].col2  = 32'(ad2_ff[r][2]);
            set_n.rows[r].shift = sat[r];
         end else begin
            set_n.rows[r] = '0;
         end
      end
      set_n.degenerate = !okd2_ff;
   end

   // ------------------------------------------------------------------
   // row serializer doubles as the output register
   // ------------------------------------------------------------------
   lav_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vd2_ff),
      .in_set    (set_n),
      .in_ready  (ser_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // pipeline moves unless the last stage holds an item the serializer can't take
   assign en        = !vd2_ff || ser_ready;
   assign req_stall = !en;

endmodule

@@ sv/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm
// pipelined 3-vector normalizer: scale, squares, bit-serial root, divide
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int IN_W      = 33,
   parameter int SIDE_W    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [IN_W-1:0]      in_vec [3],
   input  logic        [SIDE_W-1:0]    side_in,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+2:0] out_vec [3],
   output logic                        out_ok,
   output logic        [SIDE_W-1:0]    side_out
);

   localparam int AW = FRAC_BITS + 3;
   localparam int QW = FRAC_BITS + 2;
   localparam int NW = 31 + FRAC_BITS;
   localparam int TW = 31 + QW;
   localparam int SW = $clog2(IN_W + 1);
   localparam int RB = 31;

   // stage 1: magnitudes and largest
   logic              v1_ff;
   logic [IN_W-1:0]   mag1_ff [3];
   logic [IN_W-1:0]   mag1_in [3];
   logic              neg1_ff [3];
   logic [IN_W-1:0]   top1_ff;
   logic [IN_W-1:0]   top1_in;
   logic [SIDE_W-1:0] side1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
      end
      top1_in = mag1_in[0];
      if (mag1_in[1] > top1_in) top1_in = mag1_in[1];
      if (mag1_in[2] > top1_in) top1_in = mag1_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag1_in[i];
            neg1_ff[i] <= in_vec[i][IN_W-1];
         end
         top1_ff  <= top1_in;
         side1_ff <= side_in;
      end
   end

   // stage 2: leading one of the largest sets the common scale
   logic              v2_ff;
   logic [SW-1:0]     sh2_ff;
   logic [SW-1:0]     sh2_in;
   logic              nz2_ff;
   logic [IN_W-1:0]   mag2_ff [3];
   logic              neg2_ff [3];
   logic [SIDE_W-1:0] side2_ff;

   always_comb begin
      sh2_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (top1_ff[i]) sh2_in = SW'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sh2_ff   <= sh2_in;
         nz2_ff   <= (top1_ff != '0);
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: shift so the largest lands in [2^29, 2^30)
   logic              v3_ff;
   logic [29:0]       m3_ff [3];
   logic [29:0]       m3_in [3];
   logic              neg3_ff [3];
   logic              nz3_ff;
   logic [SIDE_W-1:0] side3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m3_in[i] = 30'({mag2_ff[i], 30'd0} >> sh2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         m3_ff    <= m3_in;
         neg3_ff  <= neg2_ff;
         nz3_ff   <= nz2_ff;
         side3_ff <= side2_ff;
      end
   end

   // stage 4: squares
   logic              v4_ff;
   logic [59:0]       sq4_ff [3];
   logic [29:0]       m4_ff [3];
   logic              neg4_ff [3];
   logic              nz4_ff;
   logic [SIDE_W-1:0] side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= 60'(m3_ff[i]) * 60'(m3_ff[i]);
         end
         m4_ff    <= m3_ff;
         neg4_ff  <= neg3_ff;
         nz4_ff   <= nz3_ff;
         side4_ff <= side3_ff;
      end
   end

   // square root, one result bit per stage; index 0 holds the sum
   logic              sv_ff   [RB+1];
   logic [61:0]       rem_ff  [RB+1];
   logic [30:0]       root_ff [RB+1];
   logic [29:0]       sm_ff   [RB+1][3];
   logic              sneg_ff [RB+1][3];
   logic              snz_ff  [RB+1];
   logic [SIDE_W-1:0] sside_ff[RB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v4_ff;
      end
      if (en) begin
         rem_ff[0]   <= 62'(sq4_ff[0]) + 62'(sq4_ff[1]) + 62'(sq4_ff[2]);
         root_ff[0]  <= '0;
         sm_ff[0]    <= m4_ff;
         sneg_ff[0]  <= neg4_ff;
         snz_ff[0]   <= nz4_ff;
         sside_ff[0] <= side4_ff;
      end
   end

   for (genvar k = 0; k < RB; k++) begin : g_root
      localparam int B = RB - 1 - k;
      logic [62:0] trial;
      logic        fits;
      assign trial = (63'(root_ff[k]) << (B + 1)) + (63'(1) << (2 * B));
      assign fits  = (63'(rem_ff[k]) >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (en) begin
            rem_ff[k+1]   <= fits ? 62'(63'(rem_ff[k]) - trial) : rem_ff[k];
            root_ff[k+1]  <= fits ? (root_ff[k] | (31'(1) << B)) : root_ff[k];
            sm_ff[k+1]    <= sm_ff[k];
            sneg_ff[k+1]  <= sneg_ff[k];
            snz_ff[k+1]   <= snz_ff[k];
            sside_ff[k+1] <= sside_ff[k];
         end
      end
   end

   // restoring divide, one quotient bit per stage; index 0 holds numerators
   logic              dv_ff   [QW+1];
   logic [NW-1:0]     drem_ff [QW+1][3];
   logic [QW-1:0]     q_ff    [QW+1][3];
   logic [30:0]       len_ff  [QW+1];
   logic              dneg_ff [QW+1][3];
   logic              dnz_ff  [QW+1];
   logic [SIDE_W-1:0] dside_ff[QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[RB];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= (NW'(sm_ff[RB][i]) << FRAC_BITS) + NW'(root_ff[RB] >> 1);
            q_ff[0][i]    <= '0;
         end
         len_ff[0]   <= root_ff[RB];
         dneg_ff[0]  <= sneg_ff[RB];
         dnz_ff[0]   <= snz_ff[RB];
         dside_ff[0] <= sside_ff[RB];
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int B = QW - 1 - j;
      logic [TW-1:0] trial;
      assign trial = TW'(len_ff[j]) << B;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (TW'(drem_ff[j][i]) >= trial) begin
                  drem_ff[j+1][i] <= NW'(TW'(drem_ff[j][i]) - trial);
                  q_ff[j+1][i]    <= q_ff[j][i] | (QW'(1) << B);
               end else begin
                  drem_ff[j+1][i] <= drem_ff[j][i];
                  q_ff[j+1][i]    <= q_ff[j][i];
               end
            end
            len_ff[j+1]   <= len_ff[j];
            dneg_ff[j+1]  <= dneg_ff[j];
            dnz_ff[j+1]   <= dnz_ff[j];
            dside_ff[j+1] <= dside_ff[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!dnz_ff[QW]) begin
            out_vec[i] = '0;
         end else if (dneg_ff[QW][i]) begin
            out_vec[i] = -$signed(AW'(q_ff[QW][i]));
         end else begin
            out_vec[i] = $signed(AW'(q_ff[QW][i]));
         end
      end
   end

   assign out_valid = dv_ff[QW];
   assign out_ok    = dnz_ff[QW];
   assign side_out  = dside_ff[QW];

endmodule

@@ sv/lav_rows.sv @@
// ----------------------------------------------------------------------------
// lav_rows
// output register that sends one finished matrix as three row items
// ----------------------------------------------------------------------------
module lav_rows import lav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  row_set_type in_set,
   output logic        in_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic        hold_ff;
   logic        hold_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   row_set_type set_ff;
   logic        take;
   row_data_type cur;

   assign take     = hold_ff && !rsp_stall;
   assign in_ready = !hold_ff || (take && cnt_ff == ROW_BACK);

   always_comb begin
      hold_in = hold_ff;
      cnt_in  = cnt_ff;
      if (in_ready) begin
         hold_in = in_valid;
         cnt_in  = ROW_RIGHT;
      end else if (take) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         cnt_ff  <= ROW_RIGHT;
      end else begin
         hold_ff <= hold_in;
         cnt_ff  <= cnt_in;
      end
      if (in_ready && in_valid) begin
         set_ff <= in_set;
      end
   end

   always_comb begin
      case (cnt_ff)
         ROW_RIGHT: cur = set_ff.rows[0];
         ROW_UP:    cur = set_ff.rows[1];
         default:   cur = set_ff.rows[2];
      endcase
      rsp_data.row_index  = cnt_ff;
      rsp_data.col0       = cur.col0;
      rsp_data.col1       = cur.col1;
      rsp_data.col2       = cur.col2;
      rsp_data.shift      = cur.shift;
      rsp_data.degenerate = set_ff.degenerate;
      rsp_data.last_row   = (cnt_ff == ROW_BACK);
   end

   assign rsp_valid = hold_ff;

endmodule

@@ sv/lav_checker.sv @@
// ----------------------------------------------------------------------------
// lav_checker
// port-level checks of the row sequence, bound to the top level
// ----------------------------------------------------------------------------
module lav_checker import lav_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   // stalled item stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response item dropped under stall");

   // rows of one matrix follow each other in order
   a_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_data.last_row |=>
         rsp_valid && rsp_data.row_index == 2'($past(rsp_data.row_index) + 2'd1))
      else $error("row sequence broken");

   // last flag marks the back axis row only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_row == (rsp_data.row_index == ROW_BACK))
      else $error("last_row mismatch");

   // a degenerate matrix has zero rows, flag constant over the matrix
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_data.last_row |=>
         rsp_data.degenerate == $past(rsp_data.degenerate))
      else $error("degenerate flag changed inside a matrix");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.col0 == 0 && rsp_data.col1 == 0 && rsp_data.col2 == 0 &&
         rsp_data.shift == 0)
      else $error("degenerate row not zero");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
